// ===== src/bc4_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bc4_pkg
// Shared types and constants for the BC4 block encoder.
// ----------------------------------------------------------------------------
package bc4_pkg;

  localparam int unsigned TexelW      = 8;
  localparam int unsigned BlockTexels = 16;
  localparam int unsigned CountW      = $clog2(BlockTexels);
  localparam int unsigned PalSize     = 8;
  localparam int unsigned IdxW        = $clog2(PalSize);
  localparam int unsigned IdxFieldW   = BlockTexels * IdxW;
  localparam int unsigned WordW       = 2 * TexelW + IdxFieldW;

  typedef logic [TexelW-1:0]        texel_t;
  typedef logic [IdxW-1:0]          pal_idx_t;
  typedef texel_t [PalSize-1:0]     pal_t;

  // Write port of the palette build unit into the palette registers
  typedef struct packed {
    logic     vld;
    pal_idx_t slot;
    texel_t   value;
  } pal_wr_t;

endpackage

// ===== src/bc4_palette.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bc4_palette
// Two-stage interpolation unit: builds one palette entry
// ((8-s)*max + (s-1)*min) / 7 per issue, the divide done by reciprocal.
// ----------------------------------------------------------------------------
module bc4_palette import bc4_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     issue_i,
  input  pal_idx_t slot_i,
  input  texel_t   hi_i,
  input  texel_t   lo_i,
  output pal_wr_t  wr_o
);

  localparam int unsigned SumW      = 11;   // holds 7 * 255
  localparam int unsigned RecipW    = 12;
  localparam int unsigned ProdW     = SumW + RecipW;
  localparam int unsigned Div7Shift = 14;
  localparam logic [RecipW-1:0] Div7Mul = 12'd2341;  // ceil(2^14 / 7)

  logic [SumW-1:0]  sum_d, sum_q;
  pal_idx_t         slot_q;
  logic             vld_q;
  logic [IdxW:0]    wgt_hi, wgt_lo;
  logic [ProdW-1:0] prod;

  // Weight the end points for this slot
  always_comb begin
    wgt_hi = (IdxW+1)'(PalSize) - {1'b0, slot_i};
    wgt_lo = {1'b0, slot_i} - (IdxW+1)'(1);
    sum_d  = SumW'(wgt_hi) * SumW'(hi_i) + SumW'(wgt_lo) * SumW'(lo_i);
  end

  // Hold the weighted sum
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= issue_i;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q  <= sum_d;
    slot_q <= slot_i;
  end

  // Divide by seven: exact for sums below 2^14 / 3
  assign prod = ProdW'(sum_q) * ProdW'(Div7Mul);

  assign wr_o.vld   = vld_q;
  assign wr_o.slot  = slot_q;
  assign wr_o.value = prod[Div7Shift +: TexelW];

endmodule

// ===== src/bc4_search.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bc4_search
// Nearest-entry search for one texel: absolute error against all eight
// palette entries and a three-level minimum tree, lower index wins ties.
// ----------------------------------------------------------------------------
module bc4_search import bc4_pkg::*; (
  input  texel_t   texel_i,
  input  pal_t     pal_i,
  output pal_idx_t pick_o
);

  // Absolute error orders the entries as squared error does
  texel_t   err_abs [PalSize];
  texel_t   d1 [4];
  pal_idx_t i1 [4];
  texel_t   d2 [2];
  pal_idx_t i2 [2];

  always_comb begin
    for (int s = 0; s < PalSize; s++) begin
      err_abs[s] = (texel_i >= pal_i[s]) ? texel_i - pal_i[s] : pal_i[s] - texel_i;
    end
  end

  // Reduce pairs, taking the upper one only on a strictly smaller error
  always_comb begin
    for (int p = 0; p < 4; p++) begin
      if (err_abs[2*p+1] < err_abs[2*p]) begin
        d1[p] = err_abs[2*p+1];
        i1[p] = IdxW'(2*p+1);
      end else begin
        d1[p] = err_abs[2*p];
        i1[p] = IdxW'(2*p);
      end
    end
    for (int p = 0; p < 2; p++) begin
      if (d1[2*p+1] < d1[2*p]) begin
        d2[p] = d1[2*p+1];
        i2[p] = i1[2*p+1];
      end else begin
        d2[p] = d1[2*p];
        i2[p] = i1[2*p];
      end
    end
    pick_o = (d2[1] < d2[0]) ? i2[1] : i2[0];
  end

endmodule

// ===== src/bc4_block_encoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bc4_block_encoder
// BC4 encoder for one 4x4 block of 8-bit texels, fed one texel per item.
// ----------------------------------------------------------------------------
// Texels are taken one per cycle in row-major order while busy is low. The
// sixteenth item of a block raises busy: the shared interpolation unit
// builds the six interpolated palette entries one at a time, the last entry
// is then given time to settle, and the search unit indexes the sixteen
// stored texels one at a time. No texel is taken while busy is high.
// busy falls together with the one-cycle done_o strobe that presents the
// encoded 64-bit word; the receiver cannot stall it and must take it then.
// The first texel of the next block may be given in that same cycle.
// ----------------------------------------------------------------------------
module bc4_block_encoder import bc4_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic [7:0]       texel_value_i,
  output logic             done_o,
  output logic [WordW-1:0] block_word_o
);

  typedef enum logic [3:0] {
    StLoad   = 4'b0001,
    StPal    = 4'b0010,
    StSettle = 4'b0100,
    StSearch = 4'b1000
  } state_e;

  localparam logic [CountW-1:0] LastTexel = CountW'(BlockTexels - 1);
  localparam pal_idx_t          FirstSlot = IdxW'(2);
  localparam pal_idx_t          LastSlot  = IdxW'(PalSize - 1);

  state_e                state_d, state_q;
  logic [CountW-1:0]     cnt_d, cnt_q;
  pal_idx_t              slot_d, slot_q;
  texel_t                min_d, min_q;
  texel_t                max_d, max_q;
  logic                  done_d, done_q;
  logic                  accept;
  logic                  issue;
  logic                  last_search;
  texel_t                store_q [BlockTexels];
  texel_t                pal_q [PalSize];
  pal_t                  pal_vec;
  logic [IdxFieldW-1:0]  idx_q;
  logic [WordW-1:0]      word_q;
  pal_wr_t               pal_wr;
  pal_idx_t              pick;

  assign accept      = start && (state_q == StLoad);
  assign issue       = (state_q == StPal);
  assign last_search = (state_q == StSearch) && (cnt_q == LastTexel);

  // Sequencer
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    slot_d  = slot_q;
    min_d   = min_q;
    max_d   = max_q;
    done_d  = 1'b0;
    unique case (state_q)
      StLoad: begin
        if (accept) begin
          cnt_d = cnt_q + CountW'(1);
          if (texel_value_i < min_q) min_d = texel_value_i;
          if (texel_value_i > max_q) max_d = texel_value_i;
          if (cnt_q == LastTexel) state_d = StPal;
        end
      end
      StPal: begin
        slot_d = slot_q + IdxW'(1);
        if (slot_q == LastSlot) state_d = StSettle;
      end
      StSettle: begin
        slot_d  = FirstSlot;
        state_d = StSearch;
      end
      StSearch: begin
        cnt_d = cnt_q + CountW'(1);
        if (last_search) begin
          done_d  = 1'b1;
          min_d   = '1;
          max_d   = '0;
          state_d = StLoad;
        end
      end
      default: state_d = StLoad;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
      cnt_q   <= '0;
      slot_q  <= FirstSlot;
      min_q   <= '1;
      max_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      slot_q  <= slot_d;
      min_q   <= min_d;
      max_q   <= max_d;
      done_q  <= done_d;
    end
  end

  // Store texels as they arrive
  always_ff @(posedge clk_i) begin
    if (accept) store_q[cnt_q] <= texel_value_i;
  end

  // Interpolated palette entries
  bc4_palette u_palette (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .issue_i(issue),
    .slot_i (slot_q),
    .hi_i   (max_q),
    .lo_i   (min_q),
    .wr_o   (pal_wr)
  );

  always_ff @(posedge clk_i) begin
    if (pal_wr.vld) pal_q[pal_wr.slot] <= pal_wr.value;
  end

  // End points sit in the first two entries
  always_comb begin
    pal_vec    = '0;
    pal_vec[0] = max_q;
    pal_vec[1] = min_q;
    for (int s = 2; s < PalSize; s++) begin
      pal_vec[s] = pal_q[s];
    end
  end

  bc4_search u_search (
    .texel_i(store_q[cnt_q]),
    .pal_i  (pal_vec),
    .pick_o (pick)
  );

  // Shift indices in from the top so texel zero lands lowest
  always_ff @(posedge clk_i) begin
    if (state_q == StSearch) begin
      idx_q <= {pick, idx_q[IdxFieldW-1:IdxW]};
    end
    if (last_search) begin
      word_q <= {pick, idx_q[IdxFieldW-1:IdxW], min_q, max_q};
    end
  end

  assign busy         = (state_q != StLoad);
  assign done_o       = done_q;
  assign block_word_o = word_q;

endmodule

// ===== src/bc4_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bc4_chk
// Port-level checks on the BC4 block encoder, bound to the top level.
// ----------------------------------------------------------------------------
module bc4_chk import bc4_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start,
  input logic             busy,
  input logic [7:0]       texel_value_i,
  input logic             done_o,
  input logic [WordW-1:0] block_word_o
);

  // A result strobe lasts one cycle only
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("done_o held for more than one cycle");

  // Encoding only begins on an accepted item
  a_busy_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start))
    else $error("busy rose without an accepted item");

  // Encoding ends exactly with a result
  a_busy_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("busy fell without a result");

  // The end points of a block keep max above or equal to min
  a_end_points: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (block_word_o[7:0] >= block_word_o[15:8]))
    else $error("block maximum below minimum");

endmodule

bind bc4_block_encoder bc4_chk u_bc4_chk (.*);

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the BC4 block encoder.
// ----------------------------------------------------------------------------
// Texels are fed one item at a time through the start/busy handshake. Each
// accepted texel also goes into a local model of the encoder, which keeps its
// own texel store and running min/max. On the sixteenth texel the model
// builds the palette, picks the nearest index for every texel and queues the
// encoded word. Every done_o strobe is checked against the oldest queued
// word. Directed blocks cover flat blocks, the full 0..255 range and texels
// that sit exactly between two palette entries. Random blocks of several
// shapes follow, first with random gaps on the sender side and a full
// drain pause, then back to back.
// ----------------------------------------------------------------------------
module testbench;
  import bc4_pkg::*;

  localparam int unsigned QuietLimit  = 2000;
  localparam int unsigned SettleCycles = 40;

  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             start         = 1'b0;
  logic             busy;
  texel_t           texel_value_i = '0;
  logic             done_o;
  logic [WordW-1:0] block_word_o;

  bc4_block_encoder DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .texel_value_i (texel_value_i),
    .done_o        (done_o),
    .block_word_o  (block_word_o)
  );

  always #1 clk_i = ~clk_i;

  // Model state of the encoder
  texel_t           held_texels [BlockTexels];
  int unsigned      fill_pos  = 0;
  texel_t           low_seen  = 8'hFF;
  texel_t           high_seen = 8'h00;
  logic [WordW-1:0] expected_words [$];

  int unsigned      error_count  = 0;
  int unsigned      quiet_cycles = 0;
  bit               idle_en      = 1'b0;

  task automatic report_mismatch(input string what, input logic [WordW-1:0] want,
                                 input logic [WordW-1:0] got);
    $display("%0t ERROR %s: expected %016h got %016h", $realtime, what, want, got);
    error_count++;
  endtask

  // Build the palette from the held min/max and index every held texel
  function automatic logic [WordW-1:0] encode_held_block();
    int unsigned      pal [PalSize];
    int unsigned      hi, lo, v, d, err, best;
    pal_idx_t         pick;
    logic [WordW-1:0] word;
    hi     = high_seen;
    lo     = low_seen;
    pal[0] = hi;
    pal[1] = lo;
    for (int s = 2; s < PalSize; s++) begin
      pal[s] = ((8 - s) * hi + (s - 1) * lo) / 7;
    end
    word       = '0;
    word[7:0]  = high_seen;
    word[15:8] = low_seen;
    for (int t = 0; t < BlockTexels; t++) begin
      v    = held_texels[t];
      pick = '0;
      best = 256 * 256;
      // strict less-than: the lower index keeps a tie
      for (int s = 0; s < PalSize; s++) begin
        d   = (v >= pal[s]) ? v - pal[s] : pal[s] - v;
        err = d * d;
        if (err < best) begin
          best = err;
          pick = pal_idx_t'(s);
        end
      end
      word[2*TexelW + IdxW*t +: IdxW] = pick;
    end
    return word;
  endfunction

  // Store one accepted texel; queue the encoded word on the last of a block
  task automatic absorb_texel(input texel_t v);
    held_texels[fill_pos] = v;
    if (v < low_seen)  low_seen  = v;
    if (v > high_seen) high_seen = v;
    if (fill_pos == BlockTexels - 1) begin
      expected_words.push_back(encode_held_block());
      fill_pos  = 0;
      low_seen  = 8'hFF;
      high_seen = 8'h00;
    end else begin
      fill_pos++;
    end
  endtask

  // Offer one item and hold it until the encoder takes it
  task automatic send_texel(input texel_t v);
    int unsigned gap;
    gap = 0;
    if (idle_en && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 10);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start         <= 1'b1;
    texel_value_i <= v;
    do @(posedge clk_i); while (busy);
    absorb_texel(v);
  endtask

  task automatic send_block(input texel_t blk [BlockTexels]);
    for (int t = 0; t < BlockTexels; t++) send_texel(blk[t]);
  endtask

  // Drop start and hold off until every queued word has come back
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk_i);
    while (expected_words.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_random_block();
    texel_t      blk [BlockTexels];
    int unsigned mode, base, span, val;
    texel_t      a, b;
    mode = $urandom_range(0, 9);
    base = $urandom_range(0, 255);
    span = $urandom_range(0, 15);
    a    = texel_t'($urandom_range(0, 255));
    b    = texel_t'($urandom_range(0, 255));
    for (int t = 0; t < BlockTexels; t++) begin
      if (mode <= 4) begin
        blk[t] = texel_t'($urandom_range(0, 255));
      end else if (mode <= 6) begin
        val    = base + $urandom_range(0, span);
        blk[t] = (val > 255) ? 8'hFF : texel_t'(val);
      end else if (mode <= 8) begin
        blk[t] = $urandom_range(0, 1) ? a : b;
      end else begin
        blk[t] = a;
      end
    end
    send_block(blk);
  endtask

  // Flat blocks at both ends of the range: all indices zero
  task automatic test_flat_blocks();
    texel_t blk [BlockTexels];
    foreach (blk[t]) blk[t] = 8'h00;
    send_block(blk);
    foreach (blk[t]) blk[t] = 8'hFF;
    send_block(blk);
  endtask

  // Full-range block with texels exactly between palette entries
  task automatic test_range_and_ties();
    texel_t blk [BlockTexels];
    blk = '{8'd0, 8'd255, 8'd18, 8'd54, 8'd127, 8'd200, 8'd36, 8'd72,
            8'd109, 8'd145, 8'd182, 8'd218, 8'd1, 8'd254, 8'd128, 8'd90};
    send_block(blk);
  endtask

  task automatic test_random_with_gaps(input int unsigned blocks);
    idle_en = 1'b1;
    repeat (blocks) send_random_block();
  endtask

  task automatic test_drain_pause();
    idle_en = 1'b1;
    repeat (2) send_random_block();
    drain_results();
    send_random_block();
  endtask

  task automatic test_back_to_back(input int unsigned blocks);
    idle_en = 1'b0;
    repeat (blocks) send_random_block();
  endtask

  // Check each done strobe against the oldest queued word
  always @(posedge clk_i) begin
    logic [WordW-1:0] want;
    if (rst_ni && done_o) begin
      if (expected_words.size() == 0) begin
        report_mismatch("block word with nothing queued", '0, block_word_o);
      end else begin
        want = expected_words.pop_front();
        if (block_word_o !== want) report_mismatch("block_word", want, block_word_o);
      end
    end
  end

  // End the run if nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QuietLimit) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_flat_blocks();
    test_range_and_ties();
    test_random_with_gaps(75);
    test_drain_pause();
    test_back_to_back(22);

    drain_results();
    repeat (SettleCycles) @(posedge clk_i);
    foreach (expected_words[i]) report_mismatch("block word never seen", expected_words[i], '0);

    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/bc4_pkg.sv
src/bc4_palette.sv
src/bc4_search.sv
src/bc4_block_encoder.sv
src/bc4_chk.sv
verif/testbench.sv
